>>> src/wtt_pkg.sv
package wtt_pkg;

  localparam int AddrW = 16;
  localparam int TickW = 16;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAIL    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic [TickW-1:0] TIMEOUT_RESET = 16'd100;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [TickW-1:0] cd;
  } slot_t;

  // per-operation controls handed to the head unit
  typedef struct packed {
    logic [1:0]       op;
    logic [AddrW-1:0] tag;
    logic [TickW-1:0] load;
    logic             allow;
    logic             done;
  } head_ctl_t;

  typedef struct packed {
    logic hit;
    logic report;
  } head_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

endpackage

>>> src/wtt_ifs.sv
interface wtt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] short_addr;

  modport source (output valid, operation, short_addr, input ready);
  modport sink (input valid, operation, short_addr, output ready);
endinterface

interface wtt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] report_addr;
  logic [4:0]  live_count;
  logic        last;

  modport source (output valid, status, report_addr, live_count, last, input ready);
  modport sink (input valid, status, report_addr, live_count, last, output ready);
endinterface

>>> src/wake_tag_timeout_table.sv
// Tag table with per-entry wake timeouts. Items are taken on req only while the block
// is idle; each one rotates the ring of SLOTS slot cells once past a single head unit,
// one slot per cycle while the output register is free or being emptied, and closes
// with a flush state. The add or remove result, or the last timeout report, is
// registered from the flush state, and the next item can be taken once the block is
// back in idle. Add and remove give one result with last set; a tick gives
// one timeout report per live slot whose counter is zero, in slot order, and no result
// when there is none. The user is to write the timeout register with cfg_we/cfg_wdata
// only while idle; the block does not enforce this. A zero value loads as one.
module wake_tag_timeout_table #(
  parameter int SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  wtt_in_if.sink       req,
  wtt_out_if.source    rsp
);
  import wtt_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_t state, state_next;

  logic [TickW-1:0] tmo;
  logic [CW-1:0]    entry_count, entry_count_next;
  logic [IW-1:0]    scan_idx, scan_idx_next;
  logic [1:0]       op, op_next;
  logic [AddrW-1:0] tag, tag_next;
  logic             allow, allow_next;
  logic             done, done_next;
  logic             pend_v, pend_v_next;
  logic [AddrW-1:0] pend_addr, pend_addr_next;

  logic             out_v, out_v_next;
  logic [1:0]       out_status, out_status_next;
  logic [AddrW-1:0] out_addr, out_addr_next;
  logic [4:0]       out_live, out_live_next;
  logic             out_last, out_last_next;

  slot_t            ring [SLOTS];
  slot_t            head_out;
  logic [SLOTS-1:0] match;
  logic             shift, step, dup;
  head_ctl_t        ctl;
  head_res_t        hres;

  // output register is free or being emptied this cycle
  assign step  = !out_v || rsp.ready;
  assign shift = (state == S_SCAN) && step;
  assign dup   = |match;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    slot_t d;
    if (i == SLOTS - 1) begin : g_tail
      assign d = head_out;
    end else begin : g_mid
      assign d = ring[i+1];
    end
    wtt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d),
      .tag   (req.short_addr),
      .q     (ring[i]),
      .match (match[i])
    );
  end

  assign ctl = '{op:    op,
                 tag:   tag,
                 load:  (tmo == '0) ? TickW'(1) : tmo,
                 allow: allow,
                 done:  done};

  wtt_head u_head (
    .s_in  (ring[0]),
    .ctl   (ctl),
    .s_out (head_out),
    .res   (hres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tmo <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      tmo <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      scan_idx    <= '0;
      done        <= 1'b0;
      pend_v      <= 1'b0;
      out_v       <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      scan_idx    <= scan_idx_next;
      done        <= done_next;
      pend_v      <= pend_v_next;
      out_v       <= out_v_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    tag        <= tag_next;
    allow      <= allow_next;
    pend_addr  <= pend_addr_next;
    out_status <= out_status_next;
    out_addr   <= out_addr_next;
    out_live   <= out_live_next;
    out_last   <= out_last_next;
  end

  always_comb begin
    logic ok;
    state_next       = state;
    entry_count_next = entry_count;
    scan_idx_next    = scan_idx;
    op_next          = op;
    tag_next         = tag;
    allow_next       = allow;
    done_next        = done;
    pend_v_next      = pend_v;
    pend_addr_next   = pend_addr;
    out_v_next       = out_v && !rsp.ready;
    out_status_next  = out_status;
    out_addr_next    = out_addr;
    out_live_next    = out_live;
    out_last_next    = out_last;
    ok               = done && (op == OP_ADD || op == OP_REMOVE);
    req.ready        = (state == S_IDLE);

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_next       = req.operation;
          tag_next      = req.short_addr;
          allow_next    = (req.short_addr != '0) &&
                          !(req.operation == OP_ADD && dup);
          done_next     = 1'b0;
          scan_idx_next = '0;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (step) begin
          done_next     = done || hres.hit;
          scan_idx_next = scan_idx + 1'b1;
          // hold one report back so the final one can carry last
          if (hres.report) begin
            if (pend_v) begin
              out_v_next      = 1'b1;
              out_status_next = ST_TIMEOUT;
              out_addr_next   = pend_addr;
              out_live_next   = 5'(entry_count);
              out_last_next   = 1'b0;
            end
            pend_v_next    = 1'b1;
            pend_addr_next = head_out.addr;
          end
          if (scan_idx == IW'(SLOTS - 1)) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (step) begin
          state_next = S_IDLE;
          if (op == OP_TICK) begin
            if (pend_v) begin
              out_v_next      = 1'b1;
              out_status_next = ST_TIMEOUT;
              out_addr_next   = pend_addr;
              out_live_next   = 5'(entry_count);
              out_last_next   = 1'b1;
              pend_v_next     = 1'b0;
            end
          end else begin
            if (ok && op == OP_ADD) begin
              entry_count_next = entry_count + 1'b1;
            end else if (ok && entry_count != '0) begin
              entry_count_next = entry_count - 1'b1;
            end
            out_v_next      = 1'b1;
            out_status_next = ok ? ST_OK : ST_FAIL;
            out_addr_next   = tag;
            out_live_next   = 5'(entry_count_next);
            out_last_next   = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rsp.valid       = out_v;
  assign rsp.status      = out_status;
  assign rsp.report_addr = out_addr;
  assign rsp.live_count  = out_live;
  assign rsp.last        = out_last;

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_v)
    else $error("held timeout report left over after an item");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(SLOTS))
    else $error("entry count above table size");

  // a tick with nothing timed out ends with no result
  a_flush_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && step && (op != OP_TICK || pend_v))
      |=> (state == S_IDLE && out_v && out_last))
    else $error("item closed without a final result");

  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_status != ST_TIMEOUT) |-> out_last)
    else $error("add or remove result without last");

endmodule

>>> src/wtt_cell.sv
module wtt_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    shift,
  input  wtt_pkg::slot_t          d,
  input  logic [15:0]             tag,
  output wtt_pkg::slot_t          q,
  output logic                    match
);
  import wtt_pkg::*;

  slot_t slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (shift) begin
      slot <= d;
    end
  end

  assign q     = slot;
  assign match = (slot.addr == tag);

endmodule

>>> src/wtt_head.sv
module wtt_head (
  input  wtt_pkg::slot_t    s_in,
  input  wtt_pkg::head_ctl_t ctl,
  output wtt_pkg::slot_t    s_out,
  output wtt_pkg::head_res_t res
);
  import wtt_pkg::*;

  always_comb begin
    logic [TickW-1:0] cd_dec;
    cd_dec = s_in.cd;
    s_out  = s_in;
    res    = '0;
    case (ctl.op)
      OP_ADD: begin
        if (ctl.allow && !ctl.done && s_in.addr == '0) begin
          s_out.addr = ctl.tag;
          s_out.cd   = ctl.load;
          res.hit    = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (ctl.allow && !ctl.done && s_in.addr == ctl.tag) begin
          s_out   = '0;
          res.hit = 1'b1;
        end
      end
      OP_TICK: begin
        if (s_in.addr != '0) begin
          if (s_in.cd != '0) begin
            cd_dec = s_in.cd - 1'b1;
          end
          s_out.cd   = cd_dec;
          res.report = (cd_dec == '0);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> bench/wake_tag_timeout_table_tb.sv
`timescale 1ns / 1ps

module wake_tag_timeout_table_tb;
  import wtt_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [1:0] OP_UNDEF = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 57;
  localparam int POOL = 20;
  localparam int N_ROWS = 25;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] addr;
    logic [4:0]  live;
    logic        last;
  } rsp_item_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  op;
    logic [15:0] value;
    bit          typed;
    logic [1:0]  status;
    logic [4:0]  live;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  wtt_in_if req_if ();
  wtt_out_if rsp_if ();

  wake_tag_timeout_table #(.SLOTS(SLOTS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the tag table
  logic [15:0] tbl_addr [SLOTS];
  logic [15:0] tbl_cd [SLOTS];
  int unsigned live_entries;
  int unsigned expired_entries;
  logic [15:0] timeout_ticks;

  rsp_item_t pending_reports [$];
  logic [15:0] addr_pool [POOL];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_active = 1'b0;
  event hold_start;
  rsp_item_t want;

  int idle_mode [4] = '{0, 87, 0, 20};
  int stall_mode [4] = '{0, 0, 87, 20};
  logic [15:0] phase_timeout [PHASES] =
    '{16'd3, 16'd1, 16'hFFFF, 16'd2, 16'd0, 16'd5, 16'd6, 16'd4};

  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_ITEM, OP_REMOVE, 16'h0000, 1'b1, ST_FAIL, 5'd0},
    '{ROW_ITEM, OP_ADD,    16'h0000, 1'b1, ST_FAIL, 5'd0},
    '{ROW_ITEM, OP_UNDEF,  16'hFFFF, 1'b1, ST_FAIL, 5'd0},
    '{ROW_ITEM, OP_TICK,   16'hFFFF, 1'b0, ST_OK,   5'd0},
    '{ROW_ITEM, OP_ADD,    16'hFFFF, 1'b1, ST_OK,   5'd1},
    '{ROW_ITEM, OP_ADD,    16'hFFFF, 1'b1, ST_FAIL, 5'd1},
    '{ROW_ITEM, OP_REMOVE, 16'h1234, 1'b1, ST_FAIL, 5'd1},
    '{ROW_CFG,  OP_ADD,    16'h0000, 1'b0, ST_OK,   5'd0},
    '{ROW_ITEM, OP_ADD,    16'h0001, 1'b1, ST_OK,   5'd2},
    '{ROW_ITEM, OP_ADD,    16'h8000, 1'b1, ST_OK,   5'd3},
    '{ROW_ITEM, OP_TICK,   16'h0000, 1'b0, ST_OK,   5'd0},
    '{ROW_ITEM, OP_REMOVE, 16'h0001, 1'b1, ST_OK,   5'd2},
    '{ROW_ITEM, OP_TICK,   16'h0000, 1'b0, ST_OK,   5'd0},
    '{ROW_ITEM, OP_ADD,    16'h0001, 1'b1, ST_OK,   5'd3},
    '{ROW_CFG,  OP_ADD,    16'hFFFF, 1'b0, ST_OK,   5'd0},
    '{ROW_ITEM, OP_ADD,    16'h5555, 1'b1, ST_OK,   5'd4},
    '{ROW_ITEM, OP_ADD,    16'hAAAA, 1'b1, ST_OK,   5'd5},
    '{ROW_ITEM, OP_TICK,   16'h0000, 1'b0, ST_OK,   5'd0},
    '{ROW_CFG,  OP_ADD,    16'h0002, 1'b0, ST_OK,   5'd0},
    '{ROW_ITEM, OP_ADD,    16'h7FFF, 1'b1, ST_OK,   5'd6},
    '{ROW_ITEM, OP_TICK,   16'h0000, 1'b0, ST_OK,   5'd0},
    '{ROW_ITEM, OP_TICK,   16'h0000, 1'b0, ST_OK,   5'd0},
    '{ROW_ITEM, OP_REMOVE, 16'h8000, 1'b1, ST_OK,   5'd5},
    '{ROW_ITEM, OP_REMOVE, 16'hFFFF, 1'b1, ST_OK,   5'd4},
    '{ROW_ITEM, OP_UNDEF,  16'h0000, 1'b1, ST_FAIL, 5'd4}
  };

  // Applies one accepted item to the table copy and queues its reports.
  function automatic void table_step(logic [1:0] op, logic [15:0] addr);
    rsp_item_t r;
    int slot;
    int hits;
    bit found;
    r.addr = addr;
    r.last = 1'b1;
    r.status = ST_FAIL;
    found = 1'b0;
    slot = -1;
    hits = 0;
    case (op)
      OP_ADD: begin
        if (addr != 16'd0 && live_entries < SLOTS) begin
          for (int s = 0; s < SLOTS; s++)
            if (tbl_addr[s] == addr) found = 1'b1;
          if (!found) begin
            for (int s = 0; s < SLOTS; s++)
              if (slot < 0 && tbl_addr[s] == 16'd0) slot = s;
            if (slot >= 0) begin
              tbl_addr[slot] = addr;
              tbl_cd[slot] = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
              live_entries++;
              r.status = ST_OK;
            end
          end
        end
      end
      OP_REMOVE: begin
        if (addr != 16'd0) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (!found && tbl_addr[s] == addr) begin
              found = 1'b1;
              if (live_entries > 0) live_entries--;
              if (tbl_cd[s] == 16'd0 && expired_entries > 0) expired_entries--;
              tbl_addr[s] = 16'd0;
              tbl_cd[s] = 16'd0;
              r.status = ST_OK;
            end
          end
        end
      end
      OP_TICK: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (tbl_addr[s] != 16'd0 && tbl_cd[s] != 16'd0) begin
            tbl_cd[s]--;
            if (tbl_cd[s] == 16'd0) expired_entries++;
          end
        end
        if (expired_entries != 0) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (tbl_addr[s] != 16'd0 && tbl_cd[s] == 16'd0) begin
              pending_reports.push_back('{ST_TIMEOUT, tbl_addr[s], live_entries[4:0], 1'b0});
              hits++;
            end
          end
          if (hits > 0) pending_reports[$].last = 1'b1;
        end
        return;
      end
      default: r.status = ST_FAIL;
    endcase
    r.live = live_entries[4:0];
    pending_reports.push_back(r);
  endfunction

  function automatic logic [15:0] pick_addr();
    if ($urandom_range(0, 99) < 85) return addr_pool[$urandom_range(0, POOL - 1)];
    return 16'($urandom_range(0, 65535));
  endfunction

  // mostly well-formed add/remove/tick traffic over a small address pool
  function automatic void random_request(output logic [1:0] op, output logic [15:0] addr);
    int roll;
    int idx;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      op = OP_ADD;
      addr = pick_addr();
    end else if (roll < 65) begin
      op = OP_REMOVE;
      idx = $urandom_range(0, SLOTS - 1);
      if ($urandom_range(0, 99) < 70 && tbl_addr[idx] != 16'd0) addr = tbl_addr[idx];
      else addr = pick_addr();
    end else if (roll < 93) begin
      op = OP_TICK;
      addr = 16'($urandom_range(0, 65535));
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          op = OP_UNDEF;
          addr = 16'($urandom_range(0, 65535));
        end
        1: begin
          op = OP_ADD;
          addr = 16'd0;
        end
        default: begin
          op = OP_REMOVE;
          addr = 16'd0;
        end
      endcase
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch %s: got %0h, wanted %0h at %0t", what, got, exp_val, $realtime);
  endtask

  task automatic send_request(logic [1:0] op, logic [15:0] addr);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.short_addr <= addr;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    table_step(op, addr);
    @(negedge clk);
  endtask

  // a tick may finish with no report, so allow the block to settle too
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_timeout(logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    timeout_ticks = value;
  endtask

  always @(negedge clk) begin
    if (rst || hold_active) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    forever begin
      @(hold_start);
      @(posedge clk);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected result, addr", 32'(rsp_if.report_addr), 32'd0);
      end else begin
        want = pending_reports.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
        if (rsp_if.report_addr !== want.addr)
          report_mismatch("report_addr", 32'(rsp_if.report_addr), 32'(want.addr));
        if (rsp_if.live_count !== want.live)
          report_mismatch("live_count", 32'(rsp_if.live_count), 32'(want.live));
        if (rsp_if.last !== want.last)
          report_mismatch("last", 32'(rsp_if.last), 32'(want.last));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [1:0] op;
    logic [15:0] addr;
    rsp_item_t typed_r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 16'd0;
    req_if.valid = 1'b0;
    req_if.operation = OP_ADD;
    req_if.short_addr = 16'd0;
    rsp_if.ready = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      tbl_addr[s] = 16'd0;
      tbl_cd[s] = 16'd0;
    end
    live_entries = 0;
    expired_entries = 0;
    timeout_ticks = TIMEOUT_RESET;
    for (int k = 0; k < POOL; k++) addr_pool[k] = 16'($urandom_range(1, 65535));
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int n = 0; n < N_ROWS; n++) begin
      if (directed_rows[n].kind == ROW_CFG) begin
        drain_results();
        write_timeout(directed_rows[n].value);
      end else begin
        send_request(directed_rows[n].op, directed_rows[n].value);
        if (directed_rows[n].typed) begin
          void'(pending_reports.pop_back());
          typed_r.status = directed_rows[n].status;
          typed_r.addr = directed_rows[n].value;
          typed_r.live = directed_rows[n].live;
          typed_r.last = 1'b1;
          pending_reports.push_back(typed_r);
        end
      end
    end
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      idle_pct = idle_mode[p % 4];
      stall_pct = stall_mode[p % 4];
      if (p == 6) write_timeout(16'($urandom_range(1, 9)));
      else write_timeout(phase_timeout[p]);
      // long receiver hold while items keep coming, so the block backs up
      if (p == 4) ->hold_start;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        random_request(op, addr);
        send_request(op, addr);
      end
      drain_results();
    end

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
src/wtt_pkg.sv
src/wtt_ifs.sv
src/wtt_cell.sv
src/wtt_head.sv
src/wake_tag_timeout_table.sv
bench/wake_tag_timeout_table_tb.sv
